[sv/kvte_pkg.sv]
// shared types, codes and constants of the key/value table engine
`timescale 1ns / 1ps

package kvte_pkg;

   localparam int CAPACITY_DEFAULT = 512;

   localparam int OP_W     = 3;
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int SLOT_W   = 9;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 9;
   localparam int COUNT_W  = 10;

   localparam logic [VAL_W-1:0] NOT_FOUND_VALUE = '1;

   typedef enum logic [OP_W-1:0] {
      OP_ACCUM  = 3'd0,
      OP_SET    = 3'd1,
      OP_APPEND = 3'd2,
      OP_LOOKUP = 3'd3,
      OP_REMOVE = 3'd4,
      OP_POP    = 3'd5,
      OP_READ   = 3'd6,
      OP_CLEAR  = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_SCAN = 2'd0,
      RD_LAST = 2'd1,
      RD_SLOT = 2'd2
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_UPDATE = 2'd0,
      WR_APPEND = 2'd1,
      WR_MOVE   = 2'd2
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2,
      CNT_CLR  = 2'd3
   } cnt_op_type;

   typedef enum logic [2:0] {
      RES_UPDATE = 3'd0,
      RES_FOUND  = 3'd1,
      RES_APPEND = 3'd2,
      RES_FULL   = 3'd3,
      RES_MISS   = 3'd4,
      RES_ENTRY  = 3'd5,
      RES_CLEAR  = 3'd6
   } res_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        scan_clr;
      logic        scan_run;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      cnt_op_type  cnt_op;
      logic        res_en;
      res_sel_type res_sel;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   match;
      logic   scan_miss;
      logic   at_last;
      logic   empty;
      logic   full;
      logic   slot_ok;
      logic   out_free;
   } stat_type;

endpackage

[sv/kvte_if.sv]
// request and response channel interfaces
`timescale 1ns / 1ps

interface kvte_req_if;
   import kvte_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [KEY_W-1:0]  key;
   logic signed [VAL_W-1:0]  value;
   logic [SLOT_W-1:0]        slot_index;

   modport source (output valid, op, key, value, slot_index, input ready);
   modport sink   (input valid, op, key, value, slot_index, output ready);
endinterface

interface kvte_rsp_if;
   import kvte_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic                     hit;
   logic signed [KEY_W-1:0]  key_out;
   logic signed [VAL_W-1:0]  value_out;
   logic [POS_W-1:0]         position;
   logic [COUNT_W-1:0]       count_out;

   modport source (output valid, status, hit, key_out, value_out, position, count_out,
                   input ready);
   modport sink   (input valid, status, hit, key_out, value_out, position, count_out,
                   output ready);
endinterface

[sv/kvte_dpath.sv]
// datapath: key/value memories, entry count, scan pipeline and result registers
`timescale 1ns / 1ps

module kvte_dpath #(
   parameter int CAPACITY = kvte_pkg::CAPACITY_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  kvte_pkg::cmd_type                cmd,
   output kvte_pkg::stat_type               stat,
   input  logic [kvte_pkg::OP_W-1:0]        req_op,
   input  logic signed [kvte_pkg::KEY_W-1:0] req_key,
   input  logic signed [kvte_pkg::VAL_W-1:0] req_value,
   input  logic [kvte_pkg::SLOT_W-1:0]      req_slot_index,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [kvte_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_hit,
   output logic signed [kvte_pkg::KEY_W-1:0] rsp_key_out,
   output logic signed [kvte_pkg::VAL_W-1:0] rsp_value_out,
   output logic [kvte_pkg::POS_W-1:0]       rsp_position,
   output logic [kvte_pkg::COUNT_W-1:0]     rsp_count_out
);
   import kvte_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [KEY_W-1:0] key_mem [CAPACITY];
   logic [VAL_W-1:0] val_mem [CAPACITY];

   op_type           op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]    hit_pos_ff, hit_pos_in;
   logic [AW-1:0]    fetch_idx_ff, fetch_idx_in;
   logic [KEY_W-1:0] key_q_ff;
   logic [VAL_W-1:0] val_q_ff;

   status_type       res_status_ff, res_status_in;
   logic             res_hit_ff, res_hit_in;
   logic [KEY_W-1:0] res_key_ff, res_key_in;
   logic [VAL_W-1:0] res_val_ff, res_val_in;
   logic [AW-1:0]    res_pos_ff, res_pos_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [VAL_W-1:0]   rsp_val_ff, rsp_val_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic             scan_issue, mem_rd, key_eq, at_last, out_free;
   logic [CW-1:0]    last_w;
   logic [AW-1:0]    last_idx, slot_idx, rd_addr, wr_addr;
   logic [31:0]      slot_w, count_w, pos_w;
   logic [KEY_W-1:0] wr_key;
   logic [VAL_W-1:0] wr_val, upd_val;

   // address and compare logic
   always_comb begin
      last_w     = count_ff - CW'(1);
      last_idx   = last_w[AW-1:0];
      slot_w     = 32'(slot_ff);
      slot_idx   = slot_w[AW-1:0];
      count_w    = 32'(count_ff);
      scan_issue = cmd.scan_run && (scan_ff < count_ff);
      mem_rd     = cmd.rd_en || scan_issue;
      key_eq     = (key_q_ff == key_ff);
      at_last    = ((CW'(cmp_idx_ff) + CW'(1)) == count_ff);
      out_free   = !rsp_valid_ff || rsp_ready;
      upd_val    = (op_ff == OP_ACCUM) ? (val_q_ff + val_ff) : val_ff;

      unique case (cmd.rd_sel)
         RD_SCAN: rd_addr = scan_ff[AW-1:0];
         RD_LAST: rd_addr = last_idx;
         RD_SLOT: rd_addr = slot_idx;
         default: rd_addr = scan_ff[AW-1:0];
      endcase

      unique case (cmd.wr_sel)
         WR_UPDATE: begin
            wr_addr = cmp_idx_ff;
            wr_key  = key_ff;
            wr_val  = upd_val;
         end
         WR_APPEND: begin
            wr_addr = count_ff[AW-1:0];
            wr_key  = key_ff;
            wr_val  = val_ff;
         end
         WR_MOVE: begin
            wr_addr = hit_pos_ff;
            wr_key  = key_q_ff;
            wr_val  = val_q_ff;
         end
         default: begin
            wr_addr = cmp_idx_ff;
            wr_key  = key_ff;
            wr_val  = upd_val;
         end
      endcase

      stat.op        = op_ff;
      stat.match     = cmp_valid_ff && key_eq;
      stat.scan_miss = (count_ff == '0) || (cmp_valid_ff && !key_eq && at_last);
      stat.at_last   = at_last;
      stat.empty     = (count_ff == '0);
      stat.full      = (count_ff == CW'(CAPACITY));
      stat.slot_ok   = (slot_w < count_w);
      stat.out_free  = out_free;
   end

   // next values of the working registers
   always_comb begin
      op_in   = cmd.load_req ? op_type'(req_op) : op_ff;
      key_in  = cmd.load_req ? req_key : key_ff;
      val_in  = cmd.load_req ? req_value : val_ff;
      slot_in = cmd.load_req ? req_slot_index : slot_ff;

      unique case (cmd.cnt_op)
         CNT_HOLD: count_in = count_ff;
         CNT_INC:  count_in = count_ff + CW'(1);
         CNT_DEC:  count_in = count_ff - CW'(1);
         CNT_CLR:  count_in = '0;
         default:  count_in = count_ff;
      endcase

      priority if (cmd.scan_clr) scan_in = '0;
      else if (scan_issue)       scan_in = scan_ff + CW'(1);
      else                       scan_in = scan_ff;

      cmp_valid_in = scan_issue;
      cmp_idx_in   = scan_issue ? scan_ff[AW-1:0] : cmp_idx_ff;
      hit_pos_in   = (cmp_valid_ff && key_eq) ? cmp_idx_ff : hit_pos_ff;
      fetch_idx_in = cmd.rd_en ? rd_addr : fetch_idx_ff;
   end

   // result staging
   always_comb begin
      res_status_in = res_status_ff;
      res_hit_in    = res_hit_ff;
      res_key_in    = res_key_ff;
      res_val_in    = res_val_ff;
      res_pos_in    = res_pos_ff;
      if (cmd.res_en) begin
         res_status_in = ST_DONE;
         res_hit_in    = 1'b0;
         res_key_in    = '0;
         res_val_in    = '0;
         res_pos_in    = '0;
         unique case (cmd.res_sel)
            RES_UPDATE: begin
               res_hit_in = 1'b1;
               res_val_in = upd_val;
               res_pos_in = cmp_idx_ff;
            end
            RES_FOUND: begin
               res_hit_in = 1'b1;
               res_val_in = val_q_ff;
               res_pos_in = cmp_idx_ff;
            end
            RES_APPEND: begin
               res_val_in = val_ff;
               res_pos_in = count_ff[AW-1:0];
            end
            RES_FULL: begin
               res_status_in = ST_FULL;
               res_val_in    = NOT_FOUND_VALUE;
            end
            RES_MISS: begin
               res_status_in = ST_MISS;
               res_val_in    = NOT_FOUND_VALUE;
            end
            RES_ENTRY: begin
               res_key_in = key_q_ff;
               res_val_in = val_q_ff;
               res_pos_in = fetch_idx_ff;
            end
            RES_CLEAR: ;
            default: ;
         endcase
      end
   end

   // output register, count shown after the operation
   always_comb begin
      pos_w         = 32'(res_pos_ff);
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.rsp_load) begin
         rsp_status_in = res_status_ff;
         rsp_hit_in    = res_hit_ff;
         rsp_key_in    = res_key_ff;
         rsp_val_in    = res_val_ff;
         rsp_pos_in    = pos_w[POS_W-1:0];
         rsp_count_in  = count_w[COUNT_W-1:0];
      end
      priority if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready)        rsp_valid_in = 1'b0;
      else                       rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
      if (mem_rd) begin
         key_q_ff <= key_mem[rd_addr];
         val_q_ff <= val_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      slot_ff       <= slot_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_pos_ff    <= hit_pos_in;
      fetch_idx_ff  <= fetch_idx_in;
      res_status_ff <= res_status_in;
      res_hit_ff    <= res_hit_in;
      res_key_ff    <= res_key_in;
      res_val_ff    <= res_val_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_value_out = rsp_val_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_count_out = rsp_count_ff;

endmodule

[sv/kvte_ctrl.sv]
// controller state machine sequencing each request over the datapath
`timescale 1ns / 1ps

module kvte_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  kvte_pkg::stat_type stat,
   output kvte_pkg::cmd_type  cmd
);
   import kvte_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_SEARCH = 6'b000100,
      S_MOVE   = 6'b001000,
      S_FETCH  = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.res_en = 1'b1;
            state_in   = S_OUT;
            unique case (stat.op)
               OP_ACCUM, OP_SET, OP_LOOKUP, OP_REMOVE: begin
                  cmd.res_en   = 1'b0;
                  cmd.scan_clr = 1'b1;
                  state_in     = S_SEARCH;
               end
               OP_APPEND: begin
                  if (stat.full) begin
                     cmd.res_sel = RES_FULL;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WR_APPEND;
                     cmd.cnt_op  = CNT_INC;
                     cmd.res_sel = RES_APPEND;
                  end
               end
               OP_POP: begin
                  if (stat.empty) begin
                     cmd.res_sel = RES_MISS;
                  end else begin
                     cmd.res_en = 1'b0;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_LAST;
                     state_in   = S_FETCH;
                  end
               end
               OP_READ: begin
                  if (stat.slot_ok) begin
                     cmd.res_en = 1'b0;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_SLOT;
                     state_in   = S_FETCH;
                  end else begin
                     cmd.res_sel = RES_MISS;
                  end
               end
               OP_CLEAR: begin
                  cmd.cnt_op  = CNT_CLR;
                  cmd.res_sel = RES_CLEAR;
               end
            endcase
         end
         S_SEARCH: begin
            priority if (stat.match) begin
               cmd.res_en = 1'b1;
               state_in   = S_OUT;
               unique case (stat.op)
                  OP_ACCUM, OP_SET: begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WR_UPDATE;
                     cmd.res_sel = RES_UPDATE;
                  end
                  OP_REMOVE: begin
                     cmd.res_sel = RES_FOUND;
                     if (stat.at_last) begin
                        cmd.cnt_op = CNT_DEC;
                     end else begin
                        // fetch the last entry to refill the freed slot
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_LAST;
                        state_in   = S_MOVE;
                     end
                  end
                  default: cmd.res_sel = RES_FOUND;
               endcase
            end else if (stat.scan_miss) begin
               cmd.res_en = 1'b1;
               state_in   = S_OUT;
               unique case (stat.op)
                  OP_ACCUM, OP_SET: begin
                     if (stat.full) begin
                        cmd.res_sel = RES_FULL;
                     end else begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = WR_APPEND;
                        cmd.cnt_op  = CNT_INC;
                        cmd.res_sel = RES_APPEND;
                     end
                  end
                  default: cmd.res_sel = RES_MISS;
               endcase
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         S_MOVE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_MOVE;
            cmd.cnt_op = CNT_DEC;
            state_in   = S_OUT;
         end
         S_FETCH: begin
            cmd.res_en  = 1'b1;
            cmd.res_sel = RES_ENTRY;
            if (stat.op == OP_POP) cmd.cnt_op = CNT_DEC;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/key_value_table_engine_unit.sv]
// Unordered key/value table with linear key search, one request at a time.
// Append, clear and the early misses go from decode straight to the output register; pop
// and read slot fetch the entry first; keyed operations scan the table until a match or a
// miss, and a remove that hits before the last entry also moves the last entry into the freed slot.
// The scan reads one memory entry per cycle and reads at most the entries in use.
// Reset clears the entry count and the control state; the memories keep their contents.
`timescale 1ns / 1ps

module key_value_table_engine_unit #(
   parameter int CAPACITY = kvte_pkg::CAPACITY_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   kvte_req_if.sink   req_if,
   kvte_rsp_if.source rsp_if
);
   import kvte_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   kvte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kvte_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_if.op),
      .req_key        (req_if.key),
      .req_value      (req_if.value),
      .req_slot_index (req_if.slot_index),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_status     (rsp_if.status),
      .rsp_hit        (rsp_if.hit),
      .rsp_key_out    (rsp_if.key_out),
      .rsp_value_out  (rsp_if.value_out),
      .rsp_position   (rsp_if.position),
      .rsp_count_out  (rsp_if.count_out)
   );

endmodule
